### hdl/xcd_pkg.sv
package xcd_pkg;

  localparam int PhaseW = 3;

  localparam logic [PhaseW-1:0] PH_START   = 3'd0;
  localparam logic [PhaseW-1:0] PH_INDEX   = 3'd1;
  localparam logic [PhaseW-1:0] PH_LEN_HI  = 3'd2;
  localparam logic [PhaseW-1:0] PH_LEN_LO  = 3'd3;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 3'd4;
  localparam logic [PhaseW-1:0] PH_CHECK   = 3'd5;
  localparam logic [PhaseW-1:0] PH_WAIT    = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_BAD_CHECK = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic REG_START_BYTE  = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_position;
    logic [7:0]  command_number;
    logic [15:0] declared_length;
    logic [2:0]  frame_status;
  } result_t;

endpackage

### hdl/xor_checked_command_deframer.sv
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | rx_byte, end_of_buffer
// out     | out_valid / out_ready  | result_kind, payload_byte, payload_position,
//         |                        | command_number, declared_length, frame_status
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word per cycle is taken while in_ready is high; a result crosses input and output registers.
// The state machine takes one registered word per cycle unless its result meets a stalled output.
// Reset clears the frame state, both pipeline valids and the registers to their defaults.
// A stalled output holds its word while the input register still takes a word that gives no result.
// The configuration port is always ready.
module xor_checked_command_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_position,
  output logic [7:0]  command_number,
  output logic [15:0] declared_length,
  output logic [2:0]  frame_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  start_byte;
  logic [15:0] max_payload;

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_eob;

  logic              has_result;
  xcd_pkg::result_t  result;
  xcd_pkg::result_t  out_word;
  logic              out_free;
  logic              advance;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign advance   = hold_valid && (!has_result || out_free);
  assign in_ready  = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte  <= 8'h00;
      max_payload <= xcd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        xcd_pkg::REG_START_BYTE:  start_byte  <= cfg_data[7:0];
        xcd_pkg::REG_MAX_PAYLOAD: max_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= rx_byte;
      hold_eob  <= end_of_buffer;
    end
  end

  xcd_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .rx_byte       (hold_byte),
    .end_of_buffer (hold_eob),
    .start_byte    (start_byte),
    .max_payload   (max_payload),
    .has_result    (has_result),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_word <= result;
    end
  end

  assign result_kind      = out_word.result_kind;
  assign payload_byte     = out_word.payload_byte;
  assign payload_position = out_word.payload_position;
  assign command_number   = out_word.command_number;
  assign declared_length  = out_word.declared_length;
  assign frame_status     = out_word.frame_status;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(advance && has_result))
    else $error("pending output word overwritten");

  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == xcd_pkg::KIND_PAYLOAD |-> frame_status == xcd_pkg::ST_OK)
    else $error("payload word carries a status");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == xcd_pkg::KIND_STATUS |->
      payload_byte == 8'h00 && payload_position == 16'h0000)
    else $error("status word carries payload data");

endmodule

### hdl/xcd_parse.sv
module xcd_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [7:0]         rx_byte,
  input  logic               end_of_buffer,
  input  logic [7:0]         start_byte,
  input  logic [15:0]        max_payload,
  output logic               has_result,
  output xcd_pkg::result_t   result
);

  logic [xcd_pkg::PhaseW-1:0] phase, phase_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [15:0] length_seen, length_seen_next;
  logic [15:0] bytes_taken, bytes_taken_next;
  logic [7:0]  index_seen, index_seen_next;
  logic        emit;
  logic [2:0]  emit_code;

  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    length_seen_next = length_seen;
    bytes_taken_next = bytes_taken;
    index_seen_next  = index_seen;
    emit             = 1'b0;
    emit_code        = xcd_pkg::ST_OK;
    has_result       = 1'b0;
    result           = '0;
    case (phase)
      xcd_pkg::PH_START: begin
        running_xor_next = 8'h00;
        length_seen_next = 16'h0000;
        bytes_taken_next = 16'h0000;
        index_seen_next  = 8'h00;
        if (rx_byte != start_byte) begin
          emit      = 1'b1;
          emit_code = xcd_pkg::ST_BAD_START;
        end else begin
          running_xor_next = rx_byte;
          if (end_of_buffer) begin
            emit      = 1'b1;
            emit_code = xcd_pkg::ST_TOO_SHORT;
          end else begin
            phase_next = xcd_pkg::PH_INDEX;
          end
        end
      end
      xcd_pkg::PH_INDEX: begin
        index_seen_next  = rx_byte;
        running_xor_next = running_xor ^ rx_byte;
        if (end_of_buffer) begin
          emit      = 1'b1;
          emit_code = xcd_pkg::ST_TOO_SHORT;
        end else begin
          phase_next = xcd_pkg::PH_LEN_HI;
        end
      end
      xcd_pkg::PH_LEN_HI: begin
        running_xor_next = running_xor ^ rx_byte;
        bytes_taken_next = {rx_byte, 8'h00};
        if (end_of_buffer) begin
          emit      = 1'b1;
          emit_code = xcd_pkg::ST_TOO_SHORT;
        end else begin
          phase_next = xcd_pkg::PH_LEN_LO;
        end
      end
      xcd_pkg::PH_LEN_LO: begin
        running_xor_next = running_xor ^ rx_byte;
        length_seen_next = {bytes_taken[15:8], rx_byte};
        bytes_taken_next = 16'h0000;
        if (length_seen_next > max_payload) begin
          emit      = 1'b1;
          emit_code = xcd_pkg::ST_TOO_LONG;
        end else if (end_of_buffer) begin
          emit      = 1'b1;
          emit_code = xcd_pkg::ST_TOO_SHORT;
        end else if (length_seen_next == 16'h0000) begin
          phase_next = xcd_pkg::PH_CHECK;
        end else begin
          phase_next = xcd_pkg::PH_PAYLOAD;
        end
      end
      xcd_pkg::PH_PAYLOAD: begin
        if (end_of_buffer) begin
          emit      = 1'b1;
          emit_code = xcd_pkg::ST_TOO_SHORT;
        end else begin
          running_xor_next        = running_xor ^ rx_byte;
          has_result              = 1'b1;
          result.result_kind      = xcd_pkg::KIND_PAYLOAD;
          result.payload_byte     = rx_byte;
          result.payload_position = bytes_taken;
          result.command_number   = index_seen;
          result.declared_length  = length_seen;
          result.frame_status     = xcd_pkg::ST_OK;
          bytes_taken_next        = bytes_taken + 16'd1;
          if (bytes_taken_next >= length_seen) begin
            phase_next = xcd_pkg::PH_CHECK;
          end
        end
      end
      xcd_pkg::PH_CHECK: begin
        emit      = 1'b1;
        emit_code = (rx_byte == running_xor) ? xcd_pkg::ST_OK : xcd_pkg::ST_BAD_CHECK;
      end
      default: begin
        phase_next = end_of_buffer ? xcd_pkg::PH_START : xcd_pkg::PH_WAIT;
      end
    endcase
    if (emit) begin
      has_result              = 1'b1;
      result.result_kind      = xcd_pkg::KIND_STATUS;
      result.payload_byte     = 8'h00;
      result.payload_position = 16'h0000;
      result.command_number   = index_seen_next;
      result.declared_length  = length_seen_next;
      result.frame_status     = emit_code;
      phase_next = end_of_buffer ? xcd_pkg::PH_START : xcd_pkg::PH_WAIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= xcd_pkg::PH_START;
      running_xor <= 8'h00;
      length_seen <= 16'h0000;
      bytes_taken <= 16'h0000;
      index_seen  <= 8'h00;
    end else if (advance) begin
      phase       <= phase_next;
      running_xor <= running_xor_next;
      length_seen <= length_seen_next;
      bytes_taken <= bytes_taken_next;
      index_seen  <= index_seen_next;
    end
  end

  a_status_leaves_frame: assert property (@(posedge clk) disable iff (rst)
    advance && has_result && result.result_kind == xcd_pkg::KIND_STATUS |=>
      phase == xcd_pkg::PH_START || phase == xcd_pkg::PH_WAIT)
    else $error("status did not end the frame");

  a_payload_within_length: assert property (@(posedge clk) disable iff (rst)
    has_result && result.result_kind == xcd_pkg::KIND_PAYLOAD |->
      result.payload_position < result.declared_length)
    else $error("payload word beyond declared length");

  a_phase_known: assert property (@(posedge clk) disable iff (rst)
    phase <= xcd_pkg::PH_WAIT)
    else $error("frame phase left the defined codes");

endmodule
